// File: hw/rtl/swmj_pkg.sv
// ----------------------------------------------------------------------------
// swmj_pkg: shared types and constants
// Request and result structs, cell data, control group and sizing constants
// for the sliding-window median and jitter block.
// ----------------------------------------------------------------------------
package swmj_pkg;

  localparam int RING_SLOTS = 25;
  localparam int WIN_DEPTH  = RING_SLOTS - 1;
  localparam int CNT_W      = $clog2(WIN_DEPTH + 1);
  localparam int IDX_W      = $clog2(RING_SLOTS);
  localparam int SCAN_W     = $clog2(WIN_DEPTH);
  localparam int DATA_W     = 32;
  localparam int FILL_W     = 5;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic signed [DATA_W-1:0] jitter_center;
  } in_req_t;

  typedef struct packed {
    logic                     wrapped;
    logic signed [DATA_W-1:0] median;
    logic        [DATA_W-1:0] jitter;
    logic        [FILL_W-1:0] fill_count;
  } out_rsp_t;

  // Value moved between neighbouring cells
  typedef struct packed {
    logic                     vld;
    logic signed [DATA_W-1:0] smp;
    logic        [DATA_W-1:0] dev;
  } cell_val_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic scan;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_PICK
  } state_t;

endpackage

// File: hw/rtl/swmj_cell.sv
// ----------------------------------------------------------------------------
// swmj_cell: one window cell
// Holds one sample and its deviation, and ranks them against the values
// that circulate through the row.
// ----------------------------------------------------------------------------
module swmj_cell
  import swmj_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_ctrl_t               ctrl_i,
  input  cell_val_t                prev_i,
  input  cell_val_t                circ_i,
  input  logic signed [DATA_W-1:0] center_i,
  input  logic        [CNT_W-1:0]  target_i,
  output cell_val_t                own_o,
  output cell_val_t                circ_o,
  output logic                     hit_med_o,
  output logic                     hit_jit_o
);

  logic                     vld_r;
  logic signed [DATA_W-1:0] smp_r;
  logic        [DATA_W-1:0] dev_r;
  cell_val_t                circ_r;
  logic        [CNT_W-1:0]  below_s_r, upto_s_r, below_d_r, upto_d_r;

  logic signed [DATA_W:0]   diff;
  logic        [DATA_W:0]   diff_neg;
  logic        [DATA_W-1:0] adev;
  logic                     cmp_en;

  assign diff     = {smp_r[DATA_W-1], smp_r} - {center_i[DATA_W-1], center_i};
  assign diff_neg = ~diff + 1'b1;
  assign adev     = diff[DATA_W] ? diff_neg[DATA_W-1:0] : diff[DATA_W-1:0];
  assign cmp_en   = circ_r.vld && vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctrl_i.shift) begin
      vld_r <= prev_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.shift) begin
      smp_r <= prev_i.smp;
    end
    if (ctrl_i.load) begin
      dev_r  <= adev;
      circ_r <= '{vld: vld_r, smp: smp_r, dev: adev};
    end else if (ctrl_i.scan) begin
      circ_r <= circ_i;
    end
  end

  // Rank counters: strictly below and up to (inclusive) own value
  always_ff @(posedge clk) begin
    if (ctrl_i.load) begin
      below_s_r <= '0;
      upto_s_r  <= '0;
      below_d_r <= '0;
      upto_d_r  <= '0;
    end else if (ctrl_i.scan && cmp_en) begin
      below_s_r <= below_s_r + CNT_W'($signed(circ_r.smp) <  $signed(smp_r));
      upto_s_r  <= upto_s_r  + CNT_W'($signed(circ_r.smp) <= $signed(smp_r));
      below_d_r <= below_d_r + CNT_W'(circ_r.dev <  dev_r);
      upto_d_r  <= upto_d_r  + CNT_W'(circ_r.dev <= dev_r);
    end
  end

  assign own_o     = '{vld: vld_r, smp: smp_r, dev: dev_r};
  assign circ_o    = circ_r;
  assign hit_med_o = vld_r && (below_s_r <= target_i) && (target_i < upto_s_r);
  assign hit_jit_o = vld_r && (below_d_r <= target_i) && (target_i < upto_d_r);

endmodule

// File: hw/rtl/swmj_ctrl.sv
// ----------------------------------------------------------------------------
// swmj_ctrl: sequencer
// Steps each request through shift, load, a full rotation of the row and
// the pick of the result.
// ----------------------------------------------------------------------------
module swmj_ctrl
  import swmj_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       out_busy,
  output logic       in_ready,
  output logic       pick_en,
  output cell_ctrl_t ctrl_o
);

  state_t              state_r, state_nxt;
  logic   [SCAN_W-1:0] scan_cnt_r, scan_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    in_ready     = 1'b0;
    pick_en      = 1'b0;
    ctrl_o       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        ctrl_o.shift = in_valid;
        if (in_valid) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ctrl_o.load  = 1'b1;
        scan_cnt_nxt = '0;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        ctrl_o.scan = 1'b1;
        if (scan_cnt_r == SCAN_W'(WIN_DEPTH - 1)) begin
          state_nxt = ST_PICK;
        end else begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end
      ST_PICK: begin
        // hold until the result register is free
        if (!out_busy) begin
          pick_en   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/sliding_window_median_jitter_top.sv
// ----------------------------------------------------------------------------
// sliding_window_median_jitter_top: windowed median and jitter
// Keeps the last RING_SLOTS-1 samples in a row of cells and reports the
// upper median of the samples and of their absolute deviations.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready/in_data): one request carries a signed
//   Q16.16 sample and the centre for the deviations. Output channel
//   (out_valid/out_ready/out_data): one result per request with the wrap
//   flag, the median, the jitter and the fill count.
//   Sequence: the shift happens at the accepting edge, then a load of the
//   deviations, a rotation of the values through the WIN_DEPTH (24) cells
//   of the row, and a pick step after which out_valid rises.
//   Pacing: one request at a time; the next is taken only after the
//   pick, the rotation of the cell row is the longest step, each cell seeing
//   one neighbour value per cycle, and in_ready comes back after the pick.
//   in_ready is high only between requests; a new request is taken while a
//   finished result still waits in the output register.
//   Reset: rst_n clears the window, the write slot and the fill count, and
//   drops any pending result.
//   Stall: when the receiver holds out_ready low, the result stays in the
//   output register; a following request is worked on and then waits in
//   the pick step until the register is free.
// ----------------------------------------------------------------------------
module sliding_window_median_jitter_top
  import swmj_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_data
);

  cell_ctrl_t ctrl;
  logic       pick_en;
  logic       accept;

  cell_val_t  own    [WIN_DEPTH];
  cell_val_t  circ   [WIN_DEPTH];
  cell_val_t  prev   [WIN_DEPTH];
  cell_val_t  circ_in[WIN_DEPTH];
  logic [WIN_DEPTH-1:0] hit_med, hit_jit;

  logic signed [DATA_W-1:0] center_r;
  logic        [CNT_W-1:0]  count_r, count_nxt;
  logic        [IDX_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic                     last_slot;
  logic                     wrapped_r;
  logic                     out_valid_r, out_valid_nxt;
  out_rsp_t                 out_data_r;
  logic        [CNT_W-1:0]  target;
  logic signed [DATA_W-1:0] med_sel;
  logic        [DATA_W-1:0] jit_sel;

  assign accept = in_valid && in_ready;

  swmj_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_valid_r && !out_ready),
    .in_ready (in_ready),
    .pick_en  (pick_en),
    .ctrl_o   (ctrl)
  );

  // Target rank: upper median of the current fill
  assign target = count_r >> 1;

  // Shift line feeds from the request; the rotation closes the ring
  always_comb begin
    for (int k = 0; k < WIN_DEPTH; k++) begin
      if (k == 0) begin
        prev[k]    = '{vld: 1'b1, smp: in_data.sample, dev: '0};
        circ_in[k] = circ[WIN_DEPTH-1];
      end else begin
        prev[k]    = own[k-1];
        circ_in[k] = circ[k-1];
      end
    end
  end

  for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_cell
    swmj_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl_i    (ctrl),
      .prev_i    (prev[g]),
      .circ_i    (circ_in[g]),
      .center_i  (center_r),
      .target_i  (target),
      .own_o     (own[g]),
      .circ_o    (circ[g]),
      .hit_med_o (hit_med[g]),
      .hit_jit_o (hit_jit[g])
    );
  end

  // Ties give equal values in every hitting cell, so OR them together
  always_comb begin
    med_sel = '0;
    jit_sel = '0;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      med_sel = med_sel | (hit_med[k] ? own[k].smp : '0);
      jit_sel = jit_sel | (hit_jit[k] ? own[k].dev : '0);
    end
  end

  // Ring bookkeeping: write slot (wrapping) and fill count (held at WIN_DEPTH) advance on each request
  assign last_slot  = (wr_idx_r == IDX_W'(RING_SLOTS - 1));
  assign wr_idx_nxt = last_slot ? '0 : wr_idx_r + 1'b1;
  assign count_nxt  = (count_r == CNT_W'(WIN_DEPTH)) ? count_r : count_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      count_r  <= '0;
    end else if (accept) begin
      wr_idx_r <= wr_idx_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      center_r  <= in_data.jitter_center;
      wrapped_r <= last_slot;
    end
  end

  // Output register: load on pick, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pick_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pick_en) begin
      out_data_r <= '{wrapped:    wrapped_r,
                      median:     med_sel,
                      jitter:     jit_sel,
                      fill_count: FILL_W'(count_r)};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/swmj_checker.sv
// ----------------------------------------------------------------------------
// swmj_checker: port-level checks
// Watches the ports of the top level over time; bound to it below.
// ----------------------------------------------------------------------------
module swmj_checker
  import swmj_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input out_rsp_t out_data
);

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // One request at a time: no second request right after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken on consecutive cycles");

  // The last slot is reached only with a full window
  a_wrap_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.wrapped) |-> (out_data.fill_count == FILL_W'(WIN_DEPTH)))
    else $error("wrap reported with a partial window");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind sliding_window_median_jitter_top swmj_checker u_swmj_checker (.*);

// File: sim/swmj_window_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmj_window_checker: result checker for the windowed median and jitter
// Watches both handshake channels and keeps its own copy of the sample ring.
// Each accepted request yields the expected wrap flag, median, jitter and
// fill count. Each accepted result is compared with the oldest of those.
// ----------------------------------------------------------------------------
module swmj_window_checker
  import swmj_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  in_req_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  out_rsp_t out_data,
  output int       fail_count,
  output int       pending,
  output int       checked,
  output int       wraps_seen
);

  logic signed [DATA_W-1:0] ring_samples [RING_SLOTS];
  int                       head_slot;
  int                       write_slot;
  out_rsp_t                 window_stats_q [$];
  out_rsp_t                 want;
  out_rsp_t                 next_stats;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    wraps_seen = 0;
    head_slot  = 0;
    write_slot = 0;
  end

  // Value at sorted position n/2; equal values share one rank span
  function automatic longint upper_median(input longint vals[RING_SLOTS], input int n);
    int target;
    int below;
    int upto;
    int i;
    int j;
    target = n / 2;
    for (i = 0; i < n; i++) begin
      below = 0;
      upto  = 0;
      for (j = 0; j < n; j++) begin
        if (vals[j] < vals[i]) below++;
        if (vals[j] <= vals[i]) upto++;
      end
      if (below <= target && target < upto) return vals[i];
    end
    return vals[0];
  endfunction

  task automatic append_sample(input in_req_t req, output out_rsp_t stats);
    int     wr;
    int     hd;
    int     nxt;
    int     n;
    int     h;
    longint dif;
    longint med;
    longint jit;
    longint vals [RING_SLOTS];
    longint devs [RING_SLOTS];
    wr  = write_slot;
    hd  = head_slot;
    nxt = (wr + 1) % RING_SLOTS;
    stats.wrapped = (wr == RING_SLOTS - 1) ? 1'b1 : 1'b0;
    // drop the oldest sample once the ring is full
    if (nxt == hd) hd = (hd + 1) % RING_SLOTS;
    ring_samples[wr] = req.sample;
    write_slot = nxt;
    head_slot  = hd;
    n = 0;
    h = hd;
    while (h != nxt && n < RING_SLOTS) begin
      vals[n] = longint'(ring_samples[h]);
      dif     = vals[n] - longint'(req.jitter_center);
      devs[n] = (dif < 0) ? -dif : dif;
      n++;
      h = (h + 1) % RING_SLOTS;
    end
    med = upper_median(vals, n);
    jit = upper_median(devs, n);
    stats.median     = med[DATA_W-1:0];
    stats.jitter     = jit[DATA_W-1:0];
    stats.fill_count = FILL_W'(n);
  endtask

  task automatic note_mismatch(input string field, input logic [DATA_W-1:0] exp_val,
                               input logic [DATA_W-1:0] act_val);
    fail_count++;
    $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, exp_val, act_val);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      window_stats_q.delete();
      head_slot  = 0;
      write_slot = 0;
      pending    = 0;
    end else begin
      // results first: a result always belongs to an older request
      if (out_valid && out_ready) begin
        if (window_stats_q.size() == 0) begin
          fail_count++;
          $display("%0t ns: result with no request outstanding, expected none, actual %h",
                   $time, out_data);
        end else begin
          want = window_stats_q.pop_front();
          if (out_data.wrapped !== want.wrapped)
            note_mismatch("wrapped", DATA_W'(want.wrapped), DATA_W'(out_data.wrapped));
          if (out_data.median !== want.median)
            note_mismatch("median", want.median, out_data.median);
          if (out_data.jitter !== want.jitter)
            note_mismatch("jitter", want.jitter, out_data.jitter);
          if (out_data.fill_count !== want.fill_count)
            note_mismatch("fill_count", DATA_W'(want.fill_count),
                          DATA_W'(out_data.fill_count));
          checked++;
          if (want.wrapped) wraps_seen++;
        end
      end
      if (in_valid && in_ready) begin
        append_sample(in_data, next_stats);
        window_stats_q.insert(window_stats_q.size(), next_stats);
      end
      pending = window_stats_q.size();
    end
  end

endmodule

// File: sim/tb_sliding_window_median_jitter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_median_jitter_top: testbench for the windowed median
// Drives speed samples with centre values into the block, first a directed
// set (extremes, widest deviations, ties, ring wrap) and then four random
// pacing phases. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_sliding_window_median_jitter_top
  import swmj_pkg::*;
();

  localparam int PHASE_ITEMS = 245;
  localparam int IDLE_LIMIT  = 2000;   // cycles without any handshake
  localparam int DRAIN_WAIT  = 60;     // time left for stray results after the drain

  localparam logic [DATA_W-1:0] S_MAX  = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] S_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] S_ONE  = 32'h0001_0000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_data;

  int fail_count;
  int pending;
  int checked;
  int wraps_seen;

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int sent         = 0;
  int idle_cycles  = 0;
  logic [DATA_W-1:0] speed_level = 32'h0010_0000;

  always #10 clk = ~clk;

  sliding_window_median_jitter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  swmj_window_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .wraps_seen (wraps_seen)
  );

  // Receiver: stall at random at the current phase's rate
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: reset the count on any handshake, give up after a long silence
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request, called at a falling edge; return at the falling edge
  // after it has been taken. Valid is left high: the caller either offers the
  // next request or lowers it, never both in one step.
  task automatic send_request(input logic [DATA_W-1:0] smp, input logic [DATA_W-1:0] ctr);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid              <= 1'b1;
    in_data.sample        <= smp;
    in_data.jitter_center <= ctr;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  // Hold the sender off until every outstanding result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Mostly samples clustered round a drifting speed level, plus tie-heavy
  // small values, full-range noise, the two extremes and negative values
  function automatic logic [DATA_W-1:0] pick_value(input logic [DATA_W-1:0] level);
    logic [DATA_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = level + $urandom_range(32'h0003_0000) - 32'h0001_8000;
      5, 6:          v = $urandom_range(3) << 16;
      7:             v = $urandom();
      8:             v = $urandom_range(1) ? S_MAX : S_MIN;
      default:       v = -$urandom_range(32'h0010_0000);
    endcase
    return v;
  endfunction

  initial begin
    int ph;
    int k;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero, widest deviations both ways, extremes, signs, ties,
    // then a ramp so the 25th request lands in the last slot and wraps
    send_request('0, '0);
    send_request(S_MAX, S_MIN);
    send_request(S_MIN, S_MAX);
    send_request(S_MIN, S_MIN);
    send_request(32'hffff_ffff, '0);
    send_request(32'h0000_0001, '0);
    for (k = 0; k < 6; k++) send_request(5 * S_ONE, 5 * S_ONE);
    for (k = 0; k < 13; k++) send_request((20 - k) * S_ONE, S_MAX - k);
    wait_for_results();

    // Random phases: no idling, sender gaps, receiver stalls, both
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_gap_pct = 0;  stall_pct = 0;  end
        1:       begin send_gap_pct = 47; stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  stall_pct = 47; end
        default: begin send_gap_pct = 27; stall_pct = 27; end
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // advance the level slowly, jump now and then
        if ($urandom_range(19) == 0) speed_level = $urandom();
        else speed_level = speed_level + $urandom_range(32'h0000_4000) - 32'h0000_2000;
        send_request(pick_value(speed_level), pick_value(speed_level));
      end
      wait_for_results();
    end

    // Drain: nothing outstanding, then let stray results show up
    stall_pct = 0;
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run covered %0d requests (directed, then four pacing phases);", sent);
    $display("%0d results compared, %0d of them from the last ring slot.",
             checked, wraps_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (pending != 0) $display("%0d expected results never arrived", pending);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
